### rtl/cic_charge_deposit_unit_defines.svh
// Assertion macros shared by the grid deposit logic.
`ifndef CIC_CHARGE_DEPOSIT_UNIT_DEFINES_SVH
`define CIC_CHARGE_DEPOSIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define CCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCD_ASSERT(lbl, prop)
`define CCD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/ccd_pkg.sv
package ccd_pkg;

    localparam int ACC_W       = 48;
    localparam int MAG_W       = 63;
    localparam int IDX_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 56;

    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 62;
    localparam logic signed [63:0] ACC_MAX64 = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN64 = -(64'sd1 <<< 47);

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_DEPOSIT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_VOL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MACRO_WEIGHT  = 3'd5;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_W2,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_QMAG,
        ST_M1_START,
        ST_M1_WAIT,
        ST_CRD_SUM,
        ST_CRD_MUL,
        ST_CRD_LIM,
        ST_SCHEME,
        ST_W_MUL1,
        ST_W_MUL2,
        ST_CIC_DEC,
        ST_C_NEXT,
        ST_DIV_WAIT,
        ST_M2_START,
        ST_M2_WAIT,
        ST_ADDR1,
        ST_ADDR2,
        ST_MEM_RD,
        ST_MEM_WR
    } t_state;

endpackage

### rtl/ccd_mulcap.sv
module ccd_mulcap
    import ccd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_a,
    input  logic [31:0]      i_b,
    output logic             o_done,
    output logic [MAG_W-1:0] o_result
);

    logic [63:0]      r_a;
    logic [31:0]      r_b;
    logic [63:0]      r_plo;
    logic [63:0]      r_phi;
    logic [3:0]       r_stage;
    logic [MAG_W-1:0] r_result;
    logic [95:0]      prod;

    assign prod = {r_phi, 32'd0} + {32'd0, r_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_stage[0]) begin
            r_plo <= 64'(r_a[31:0]) * 64'(r_b);
        end
        if (r_stage[1]) begin
            r_phi <= 64'(r_a[63:32]) * 64'(r_b);
        end
        if (r_stage[2]) begin
            r_result <= (prod > 96'(MAG_CAP)) ? MAG_CAP : MAG_W'(prod >> FRACTION_BITS);
        end
    end

    assign o_done   = r_stage[3];
    assign o_result = r_result;

endmodule

### rtl/ccd_divider.sv
module ccd_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*FRACTION_BITS:0] i_num,
    input  logic [FRACTION_BITS+3:0] i_den,
    output logic                     o_done,
    output logic [FRACTION_BITS:0]   o_quo
);

    localparam int NW   = 2 * FRACTION_BITS + 1;
    localparam int DW   = FRACTION_BITS + 4;
    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(diff) : DW'(trial);
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = (FRACTION_BITS + 1)'(r_quo);

endmodule

### rtl/cic_charge_deposit_unit.sv
// A read passes through ST_RD_W2, ST_RD_ISSUE and ST_RD_DATA to the output register, held
// in ST_RD_DATA while the output word is not taken; an unused opcode is dropped, and a clear
// sweeps all MAX_WIDTH**3 grid words. A deposit with nonzero scaled charge read-modify-writes
// the single grid memory once for nearest-point or a single fallback cell, or once per kept
// cloud-in-cell corner after the bit-serial divider. One item is worked at a time.
// After reset a sweep zeroes all MAX_WIDTH**3 grid words before the first item is taken.
`include "cic_charge_deposit_unit_defines.svh"
module cic_charge_deposit_unit
    import ccd_pkg::*;
#(
    parameter int MAX_WIDTH     = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode, pos_x, pos_y, pos_z, charge, cell_index
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // density_value, saturated_flag
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int F     = FRACTION_BITS;
    localparam int DEPTH = MAX_WIDTH * MAX_WIDTH * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int YZW   = $clog2(MAX_WIDTH * MAX_WIDTH);
    localparam int W2W   = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
    localparam int GW    = F + 14;
    localparam int WTW   = F + 1;
    localparam int SUMW  = F + 4;
    localparam logic [65:0]    FMASK66   = (66'(1) << F) - 66'(1);
    localparam logic [65:0]    CLIM66    = 66'(1) << (F + 12);
    localparam logic [GW-1:0]  HALF_G    = GW'(1) << (F - 1);
    localparam logic [WTW-1:0] ONE_W     = WTW'(1) << F;

    function automatic logic [CW-1:0] clamp_idx(input logic signed [IDX_W-1:0] v,
                                                input logic [WW-1:0] w);
        logic signed [IDX_W-1:0] hi;
        hi = $signed(IDX_W'(w)) - 1;
        if (v < 0) begin
            clamp_idx = '0;
        end else if (v > hi) begin
            clamp_idx = CW'(hi);
        end else begin
            clamp_idx = CW'(v);
        end
    endfunction

    function automatic logic signed [IDX_W-1:0] round_idx(input logic signed [GW-1:0] g);
        logic [GW-1:0] mag;
        logic [GW-1:0] r;
        mag = g[GW-1] ? GW'(-g) : GW'(g);
        r   = (mag + HALF_G) >> F;
        round_idx = g[GW-1] ? -$signed(IDX_W'(r)) : $signed(IDX_W'(r));
    endfunction

    t_state r_state;
    t_state n_state;

    logic [4:0]  r_grid_width;
    logic        r_scheme;
    logic [31:0] r_offset;
    logic [31:0] r_ics;
    logic [31:0] r_icv;
    logic [31:0] r_mw;

    logic [ACC_W-1:0] r_mem [DEPTH];
    logic [ACC_W-1:0] r_rdata;
    logic [AW-1:0]    r_clr_addr;
    logic             r_sticky;

    logic [31:0]      r_pos [3];
    logic [31:0]      r_charge;
    logic [11:0]      r_cell_index;
    logic [MAG_W-1:0] r_qmag;
    logic             r_neg;
    logic [MAG_W-1:0] r_m1;
    logic [MAG_W-1:0] r_amt;
    logic [WTW-1:0]   r_n;
    logic [1:0]       r_ax;
    logic [32:0]      r_smag;
    logic             r_sneg;
    logic [64:0]      r_p;
    logic signed [GW-1:0]    r_g [3];
    logic signed [IDX_W-1:0] r_base [3];
    logic [F-1:0]     r_t [3];
    logic [3:0]       r_k;
    logic [2*WTW-1:0] r_wxy;
    logic [WTW-1:0]   r_wz;
    logic             r_in;
    logic [WTW-1:0]   r_cw [8];
    logic [7:0]       r_cok;
    logic [SUMW-1:0]  r_wsum;
    logic             r_multi;
    logic [CW-1:0]    r_cx;
    logic [CW-1:0]    r_cy;
    logic [CW-1:0]    r_cz;
    logic [YZW-1:0]   r_yz;
    logic [AW-1:0]    r_addr;
    logic [W2W-1:0]   r_w2;
    logic             r_inrange;
    logic             r_out_valid;
    logic [ACC_W-1:0] r_out_density;
    logic             r_out_flag;

    logic [1:0]  in_opcode;
    logic [31:0] in_charge;
    logic [31:0] cmag;
    logic [WW-1:0] w_eff;
    logic signed [IDX_W-1:0] w_s;
    logic [2:0]  k3;

    logic             mc_start;
    logic [63:0]      mc_a;
    logic [31:0]      mc_b;
    logic             mc_done;
    logic [MAG_W-1:0] mc_result;
    logic             div_start;
    logic             div_done;
    logic [WTW-1:0]   div_quo;

    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [ACC_W-1:0] mem_wdata;
    logic             out_load;

    logic signed [32:0] s_sum;
    logic [65:0]        lim_raw;
    logic [65:0]        lim_mag;
    logic signed [GW-1:0] lim_g;
    logic [WTW-1:0]     wx;
    logic [WTW-1:0]     wy;
    logic [WTW-1:0]     wz;
    logic signed [IDX_W-1:0] cix;
    logic signed [IDX_W-1:0] ciy;
    logic signed [IDX_W-1:0] ciz;
    logic [2*WTW+1:0]   wprod;
    logic [WTW-1:0]     wt;
    logic [63:0]        amt64;
    logic signed [63:0] acc_add;
    logic signed [63:0] acc_sum;
    logic               sat_hi;
    logic               sat_lo;
    logic [W2W+WW-1:0]  w3;
    logic [YZW+WW-1:0]  yz_full;
    logic [AW+WW-1:0]   addr_full;

    assign in_opcode = s_axis_tdata[1:0];
    assign in_charge = s_axis_tdata[129:98];
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_eff = (r_grid_width == 5'd0) ? WW'(1) :
                   (32'(r_grid_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_grid_width);
    assign w_s   = $signed(IDX_W'(w_eff));
    assign k3    = r_k[2:0];
    assign cmag  = r_charge[31] ? (~r_charge + 32'd1) : r_charge;

    assign s_sum = $signed({r_pos[r_ax][31], r_pos[r_ax]}) + $signed({r_offset[31], r_offset});
    assign lim_raw = r_sneg ? ((66'(r_p) + FMASK66) >> F) : (66'(r_p) >> F);
    assign lim_mag = (lim_raw > CLIM66) ? CLIM66 : lim_raw;
    assign lim_g   = r_sneg ? -$signed(GW'(lim_mag)) : $signed(GW'(lim_mag));

    assign wx  = r_k[0] ? {1'b0, r_t[0]} : ONE_W - {1'b0, r_t[0]};
    assign wy  = r_k[1] ? {1'b0, r_t[1]} : ONE_W - {1'b0, r_t[1]};
    assign wz  = r_k[2] ? {1'b0, r_t[2]} : ONE_W - {1'b0, r_t[2]};
    assign cix = r_base[0] + $signed(IDX_W'(r_k[0]));
    assign ciy = r_base[1] + $signed(IDX_W'(r_k[1]));
    assign ciz = r_base[2] + $signed(IDX_W'(r_k[2]));
    assign wprod = (2*WTW+2)'(r_wxy >> F) * (2*WTW+2)'(r_wz);
    assign wt    = WTW'(wprod >> F);

    assign amt64   = {1'b0, r_amt};
    assign acc_add = r_neg ? -$signed(amt64) : $signed(amt64);
    assign acc_sum = $signed({{(64-ACC_W){r_rdata[ACC_W-1]}}, r_rdata}) + acc_add;
    assign sat_hi  = (acc_sum > ACC_MAX64);
    assign sat_lo  = (acc_sum < ACC_MIN64);

    assign w3        = (W2W+WW)'(r_w2) * (W2W+WW)'(w_eff);
    assign yz_full   = (YZW+WW)'(r_cy) + (YZW+WW)'(w_eff) * (YZW+WW)'(r_cz);
    assign addr_full = (AW+WW)'(r_cx) + (AW+WW)'(w_eff) * (AW+WW)'(r_yz);

    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
    assign mem_raddr = (r_state == ST_RD_ISSUE) ? AW'(r_cell_index) : r_addr;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 :
                       sat_hi ? ACC_W'(ACC_MAX64) :
                       sat_lo ? ACC_W'(ACC_MIN64) : ACC_W'(acc_sum);

    assign mc_a = (r_state == ST_M1_START) ? 64'(r_qmag) : 64'(r_m1);
    assign mc_b = (r_state == ST_M1_START) ? r_icv : 32'(r_n);

    always_comb begin
        n_state   = r_state;
        mc_start  = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (in_opcode)
                        OP_CLEAR:   n_state = ST_CLEAR;
                        OP_DEPOSIT: n_state = ST_QMAG;
                        OP_READ:    n_state = ST_RD_W2;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD_W2: n_state = ST_RD_ISSUE;
            ST_RD_ISSUE: begin
                mem_re  = 1'b1;
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_QMAG: n_state = ST_M1_START;
            ST_M1_START: begin
                if (r_qmag == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    mc_start = 1'b1;
                    n_state  = ST_M1_WAIT;
                end
            end
            ST_M1_WAIT: begin
                if (mc_done) begin
                    n_state = ST_CRD_SUM;
                end
            end
            ST_CRD_SUM: n_state = ST_CRD_MUL;
            ST_CRD_MUL: n_state = ST_CRD_LIM;
            ST_CRD_LIM: n_state = (r_ax == 2'd2) ? ST_SCHEME : ST_CRD_SUM;
            ST_SCHEME:  n_state = r_scheme ? ST_W_MUL1 : ST_M2_START;
            ST_W_MUL1:  n_state = ST_W_MUL2;
            ST_W_MUL2:  n_state = (k3 == 3'd7) ? ST_CIC_DEC : ST_W_MUL1;
            ST_CIC_DEC: begin
                if (r_cok == '0 || r_wsum == '0) begin
                    n_state = ST_M2_START;
                end else begin
                    n_state = ST_C_NEXT;
                end
            end
            ST_C_NEXT: begin
                if (r_k[3]) begin
                    n_state = ST_IDLE;
                end else if (r_cok[k3]) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_M2_START;
                end
            end
            ST_M2_START: begin
                mc_start = 1'b1;
                n_state  = ST_M2_WAIT;
            end
            ST_M2_WAIT: begin
                if (mc_done) begin
                    n_state = ST_ADDR1;
                end
            end
            ST_ADDR1: n_state = ST_ADDR2;
            ST_ADDR2: n_state = ST_MEM_RD;
            ST_MEM_RD: begin
                mem_re  = 1'b1;
                n_state = ST_MEM_WR;
            end
            ST_MEM_WR: begin
                mem_we  = 1'b1;
                n_state = r_multi ? ST_C_NEXT : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_sticky     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_grid_width <= 5'd16;
            r_scheme     <= 1'b1;
            r_offset     <= '0;
            r_ics        <= 32'(1) << F;
            r_icv        <= 32'(1) << F;
            r_mw         <= 32'(1) << F;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_sticky   <= 1'b0;
            end else begin
                r_clr_addr <= '0;
            end
            if (r_state == ST_MEM_WR && (sat_hi || sat_lo)) begin
                r_sticky <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:    r_grid_width <= i_cfg_wdata[4:0];
                    CFG_SCHEME:        r_scheme     <= i_cfg_wdata[0];
                    CFG_OFFSET:        r_offset     <= i_cfg_wdata;
                    CFG_INV_CELL_SIZE: r_ics        <= i_cfg_wdata;
                    CFG_INV_CELL_VOL:  r_icv        <= i_cfg_wdata;
                    CFG_MACRO_WEIGHT:  r_mw         <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_pos[0]     <= s_axis_tdata[33:2];
                r_pos[1]     <= s_axis_tdata[65:34];
                r_pos[2]     <= s_axis_tdata[97:66];
                r_charge     <= in_charge;
                r_cell_index <= s_axis_tdata[141:130];
            end
            ST_RD_W2: begin
                r_w2 <= W2W'((2*WW)'(w_eff) * (2*WW)'(w_eff));
            end
            ST_RD_ISSUE: begin
                r_inrange <= (32'(r_cell_index) < 32'(w3));
            end
            ST_RD_DATA: begin
                if (out_load) begin
                    r_out_density <= r_inrange ? r_rdata : '0;
                    r_out_flag    <= r_sticky;
                end
            end
            ST_QMAG: begin
                r_qmag <= MAG_W'(64'(cmag) * 64'(r_mw));
                r_neg  <= r_charge[31];
            end
            ST_M1_WAIT: begin
                r_m1 <= mc_result;
                r_ax <= 2'd0;
            end
            ST_CRD_SUM: begin
                r_smag <= s_sum[32] ? (~s_sum + 33'd1) : s_sum;
                r_sneg <= s_sum[32];
            end
            ST_CRD_MUL: begin
                r_p <= 65'(r_smag) * 65'(r_ics);
            end
            ST_CRD_LIM: begin
                r_g[r_ax] <= lim_g;
                r_ax      <= r_ax + 2'd1;
            end
            ST_SCHEME: begin
                r_cx    <= clamp_idx(round_idx(r_g[0]), w_eff);
                r_cy    <= clamp_idx(round_idx(r_g[1]), w_eff);
                r_cz    <= clamp_idx(round_idx(r_g[2]), w_eff);
                r_n     <= ONE_W;
                r_multi <= 1'b0;
                r_k     <= '0;
                r_wsum  <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_base[a] <= IDX_W'(r_g[a] >>> F);
                    r_t[a]    <= r_g[a][F-1:0];
                end
            end
            ST_W_MUL1: begin
                r_wxy <= (2*WTW)'(wx) * (2*WTW)'(wy);
                r_wz  <= wz;
                r_in  <= (cix >= 0) && (cix < w_s) && (ciy >= 0) && (ciy < w_s) &&
                         (ciz >= 0) && (ciz < w_s);
            end
            ST_W_MUL2: begin
                r_cw[k3]  <= wt;
                r_cok[k3] <= r_in && (wt != '0);
                r_wsum    <= r_wsum + ((r_in && (wt != '0)) ? SUMW'(wt) : '0);
                r_k       <= r_k + 4'd1;
            end
            ST_CIC_DEC: begin
                r_k     <= '0;
                r_multi <= !(r_cok == '0 || r_wsum == '0);
                r_cx    <= clamp_idx(r_base[0], w_eff);
                r_cy    <= clamp_idx(r_base[1], w_eff);
                r_cz    <= clamp_idx(r_base[2], w_eff);
                r_n     <= ONE_W;
            end
            ST_C_NEXT: begin
                if (!r_k[3]) begin
                    if (r_cok[k3]) begin
                        r_cx <= CW'(cix);
                        r_cy <= CW'(ciy);
                        r_cz <= CW'(ciz);
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
            end
            ST_DIV_WAIT: begin
                r_n <= div_quo;
            end
            ST_M2_WAIT: begin
                r_amt <= mc_result;
            end
            ST_ADDR1: begin
                r_yz <= YZW'(yz_full);
            end
            ST_ADDR2: begin
                r_addr <= AW'(addr_full);
            end
            ST_MEM_WR: begin
                r_k <= r_k + 4'd1;
            end
            default: ;
        endcase
    end

    ccd_mulcap #(
        .FRACTION_BITS(F)
    ) u_mulcap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mc_start),
        .i_a      (mc_a),
        .i_b      (mc_b),
        .o_done   (mc_done),
        .o_result (mc_result)
    );

    ccd_divider #(
        .FRACTION_BITS(F)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_cw[k3], {F{1'b0}}}),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_flag, r_out_density};

    `CCD_ASSERT(a_div_den_nonzero, div_start |-> r_wsum != '0)
    `CCD_ASSERT(a_norm_le_one, div_done |-> div_quo <= ONE_W)
    `CCD_ASSERT(a_mul_awaited, mc_done |-> r_state == ST_M1_WAIT || r_state == ST_M2_WAIT)
    `CCD_ASSERT_NEXT(a_wr_exit, r_state == ST_MEM_WR, r_state == ST_C_NEXT || r_state == ST_IDLE)

endmodule

### test/tb.sv
module tb;
    import ccd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint ONE = 64'sd65536;

    class deposit_scoreboard;
        int unsigned width_reg;
        bit scheme;
        longint offset;
        bit [63:0] inv_size;
        bit [63:0] inv_vol;
        bit [63:0] macro;
        longint grid [4096];
        bit sticky;
        bit [48:0] expected_q[$];
        int errors;

        function void reset_state();
            width_reg = 16;
            scheme = 1'b1;
            offset = 0;
            inv_size = ONE;
            inv_vol = ONE;
            macro = ONE;
            foreach (grid[i]) grid[i] = 0;
            sticky = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_GRID_WIDTH:    width_reg = val[4:0];
                CFG_SCHEME:        scheme = val[0];
                CFG_OFFSET:        offset = longint'($signed(val));
                CFG_INV_CELL_SIZE: inv_size = {32'd0, val};
                CFG_INV_CELL_VOL:  inv_vol = {32'd0, val};
                CFG_MACRO_WEIGHT:  macro = {32'd0, val};
                default: ;
            endcase
        endfunction

        function longint coord(logic [31:0] p);
            longint s;
            longint g;
            bit [63:0] m;
            bit [63:0] pr;
            s = longint'($signed(p)) + offset;
            m = (s < 0) ? -s : s;
            pr = m * inv_size;
            if (s >= 0) g = longint'(pr >> 16);
            else g = -longint'((pr + 64'd65535) >> 16);
            if (g > (64'sd1 <<< 28)) g = 64'sd1 <<< 28;
            if (g < -(64'sd1 <<< 28)) g = -(64'sd1 <<< 28);
            return g;
        endfunction

        function longint clamp_cell(longint v, longint w);
            if (v < 0) return 0;
            if (v > w - 1) return w - 1;
            return v;
        endfunction

        function longint round_cell(longint g);
            longint r;
            r = longint'(((g < 0 ? -g : g) + 32768) >>> 16);
            return (g < 0) ? -r : r;
        endfunction

        function bit [63:0] capped_mul(bit [63:0] a, bit [63:0] b);
            bit [63:0] cap;
            bit [63:0] r;
            cap = 64'd1 << 62;
            if (a != 0 && b > cap / a) return cap;
            r = (a * b) >> 16;
            return (r > cap) ? cap : r;
        endfunction

        function void add_charge(longint idx, bit [63:0] qmag, bit neg, bit [63:0] norm);
            bit [63:0] m;
            longint amount;
            longint sum;
            m = capped_mul(capped_mul(qmag, inv_vol), norm);
            amount = neg ? -longint'(m) : longint'(m);
            if (idx < 0 || idx >= 4096) return;
            sum = grid[idx] + amount;
            if (sum > ACC_MAX64) begin
                sum = ACC_MAX64;
                sticky = 1'b1;
            end else if (sum < ACC_MIN64) begin
                sum = ACC_MIN64;
                sticky = 1'b1;
            end
            grid[idx] = sum;
        endfunction

        function void deposit(logic [IN_TDATA_W-1:0] word, longint w);
            longint q;
            bit [63:0] qmag;
            longint g[3];
            longint base[3];
            bit [63:0] t[3];
            longint cidx[8];
            bit [63:0] cw[8];
            bit [63:0] wsum;
            bit [63:0] wx, wy, wz, wt;
            longint ix, iy, iz;
            int n;
            q = longint'($signed(word[129:98]));
            qmag = (q < 0 ? -q : q) * macro;
            wsum = 0;
            n = 0;
            if (qmag == 0) return;
            g[0] = coord(word[33:2]);
            g[1] = coord(word[65:34]);
            g[2] = coord(word[97:66]);
            if (!scheme) begin
                ix = clamp_cell(round_cell(g[0]), w);
                iy = clamp_cell(round_cell(g[1]), w);
                iz = clamp_cell(round_cell(g[2]), w);
                add_charge(ix + w * (iy + w * iz), qmag, q < 0, ONE);
                return;
            end
            for (int k = 0; k < 3; k++) begin
                base[k] = g[k] >>> 16;
                t[k] = {48'd0, g[k][15:0]};
            end
            for (int dz = 0; dz <= 1; dz++)
                for (int dy = 0; dy <= 1; dy++)
                    for (int dx = 0; dx <= 1; dx++) begin
                        ix = base[0] + dx;
                        iy = base[1] + dy;
                        iz = base[2] + dz;
                        wx = dx ? t[0] : ONE - t[0];
                        wy = dy ? t[1] : ONE - t[1];
                        wz = dz ? t[2] : ONE - t[2];
                        wt = (((wx * wy) >> 16) * wz) >> 16;
                        if (ix >= 0 && ix < w && iy >= 0 && iy < w && iz >= 0 && iz < w
                            && wt != 0) begin
                            cidx[n] = ix + w * (iy + w * iz);
                            cw[n] = wt;
                            wsum += wt;
                            n++;
                        end
                    end
            if (n == 0 || wsum == 0) begin
                ix = clamp_cell(base[0], w);
                iy = clamp_cell(base[1], w);
                iz = clamp_cell(base[2], w);
                add_charge(ix + w * (iy + w * iz), qmag, q < 0, ONE);
                return;
            end
            for (int k = 0; k < n; k++)
                add_charge(cidx[k], qmag, q < 0, (cw[k] << 16) / wsum);
        endfunction

        function void note_word(logic [IN_TDATA_W-1:0] word);
            longint w;
            longint idx;
            longint v;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > 16) w = 16;
            case (word[1:0])
                OP_CLEAR: begin
                    foreach (grid[i]) grid[i] = 0;
                    sticky = 1'b0;
                end
                OP_DEPOSIT: deposit(word, w);
                OP_READ: begin
                    idx = word[141:130];
                    v = (idx < w * w * w) ? grid[idx] : 0;
                    expected_q.push_back({sticky, v[47:0]});
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] data);
            bit [48:0] e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (data[47:0] !== e[47:0]) begin
                $display("%0t: density expected %h actual %h", $time, e[47:0], data[47:0]);
                errors++;
            end
            if (data[48] !== e[48]) begin
                $display("%0t: saturated flag expected %b actual %b", $time, e[48], data[48]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    deposit_scoreboard sb;
    int hold_req = 0;

    cic_charge_deposit_unit dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
                m_axis_tready = 1'b0;
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                end
            end
            m_axis_tready = ($urandom_range(0, 99) < 70);
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack(logic [1:0] op, logic [31:0] x,
        logic [31:0] y, logic [31:0] z, logic [31:0] q, logic [11:0] idx);
        return {2'b00, idx, q, z, y, x, op};
    endfunction

    task automatic send(logic [IN_TDATA_W-1:0] word);
        int g;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(word);
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] rand_pos();
        longint w;
        longint c;
        int r;
        w = sb.width_reg;
        if (w < 1) w = 1;
        if (w > 16) w = 16;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        c = longint'($urandom_range(0, 32'((w + 2) << 16))) - ONE;
        if (r < 30) c = (c & ~longint'(65535)) | (($urandom_range(0, 1)) ? 32768 : 0);
        if (sb.inv_size == 0) return $urandom;
        return 32'((c * ONE) / longint'(sb.inv_size) - sb.offset);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] rand_word();
        int r;
        longint w;
        logic [31:0] q;
        logic [11:0] idx;
        w = sb.width_reg;
        if (w < 1) w = 1;
        if (w > 16) w = 16;
        r = $urandom_range(0, 99);
        q = ($urandom_range(0, 9) < 2) ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000);
        idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, w * w * w - 1));
        if (r < 2) return pack(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 4) return pack(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (r < 50) return pack(OP_READ, $urandom, $urandom, $urandom, $urandom, idx);
        return pack(OP_DEPOSIT, rand_pos(), rand_pos(), rand_pos(), q, idx);
    endfunction

    task automatic run_phase(logic [4:0] w, bit sch, logic [31:0] off, logic [31:0] isz,
        logic [31:0] ivol, logic [31:0] mw, int count, int action);
        drain();
        repeat (5000) @(posedge i_clk);
        cfg_write(CFG_GRID_WIDTH, {27'd0, w});
        cfg_write(CFG_SCHEME, {31'd0, sch});
        cfg_write(CFG_OFFSET, off);
        cfg_write(CFG_INV_CELL_SIZE, isz);
        cfg_write(CFG_INV_CELL_VOL, ivol);
        cfg_write(CFG_MACRO_WEIGHT, mw);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && action == 1) hold_req = 3000;
            if (i == count / 2 && action == 2) drain();
            send(rand_word());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(pack(OP_READ, 0, 0, 0, 0, 12'd0));
        send(pack(OP_DEPOSIT, 0, 0, 0, 32'd1, 0));
        send(pack(OP_DEPOSIT, 32'h0008_8000, 32'h0003_4000, 32'h0007_C000, 32'd500, 0));
        send(pack(OP_DEPOSIT, 32'h000F_8000, 32'h000F_8000, 32'h000F_8000, 32'd77, 0));
        send(pack(OP_DEPOSIT, 32'hFFFD_0000, 32'h0002_0000, 32'h0030_0000, 32'd9, 0));
        send(pack(OP_DEPOSIT, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'd0, 0));
        send(pack(OP_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 0));
        send(pack(OP_DEPOSIT, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h7FFF_FFFF, 0));
        send(pack(OP_DEPOSIT, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h7FFF_FFFF, 0));
        send(pack(OP_READ, 0, 0, 0, 0, 12'd0));
        send(pack(OP_READ, 0, 0, 0, 0, 12'd1));
        send(pack(OP_READ, 0, 0, 0, 0, 12'd1365));
        send(pack(OP_READ, 0, 0, 0, 0, 12'd4095));
        send(pack(OP_UNUSED, 32'hFFFF_FFFF, 0, 0, 32'd5, 12'hFFF));
        send(pack(OP_CLEAR, 0, 0, 0, 0, 0));
        send(pack(OP_READ, 0, 0, 0, 0, 12'd1365));

        run_phase(5'd16, 1'b1, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 250, 0);
        run_phase(5'd4, 1'b0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 200, 2);
        run_phase(5'd1, 1'b1, 32'hFFFF_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            150, 0);
        run_phase(5'd0, 1'b0, 32'h0000_0001, 32'h0002_0000, 32'h0001_0000, 32'h0000_0001,
            100, 0);
        run_phase(5'd31, 1'b1, 32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            150, 1);
        run_phase(5'd8, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
            100, 0);
        run_phase(5'd5, 1'b1, 32'h0002_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0003,
            150, 0);
        run_phase(5'd16, 1'b0, 32'h0001_2345, 32'h0001_8000, 32'h0000_8000, 32'h0001_0000,
            200, 0);

        drain();
        repeat (5000) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
